// ----- src/log_page_fill_tracker_core_assert.svh -----
// Assertion macros for the log page fill tracker core.
// Needs no other file; included by the top level only.
`ifndef LOG_PAGE_FILL_TRACKER_CORE_ASSERT_SVH
`define LOG_PAGE_FILL_TRACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPFT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LPFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LPFT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LPFT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/lpft_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the log page fill tracker.
// Used by lpft_step, lpft_ctrl and the top level; depends on nothing.
package lpft_pkg;

   localparam int POS_W = 64;
   localparam int SIZE_W = 16;
   localparam int FILL_W = 13;
   localparam int DEF_BUFFER_BYTES = 65536;
   localparam int DEF_PAGE_BYTES = 4096;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic clear_we;
      logic load;
      logic rd_en;
      logic update;
      logic resp;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic clear_done;
      logic item_probe;
      logic req_probe;
      logic req_size_zero;
      logic last_chunk;
   } stat_type;

endpackage

// ----- src/lpft_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
module lpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/lpft_step.sv -----
`timescale 1ns / 1ps
// Shared step unit: splits a span at the next page boundary, forms the new fill count and flags a full page.
// Depends on lpft_pkg.
module lpft_step
   import lpft_pkg::*;
#(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES,
   localparam int OFF_W = $clog2(BUFFER_BYTES),
   localparam int PG_W = $clog2(PAGE_BYTES)
) (
   input  logic [OFF_W-1:0]  off,
   input  logic [SIZE_W-1:0] left,
   input  logic [FILL_W-1:0] fill_rd,
   output logic [SIZE_W-1:0] chunk,
   output logic [OFF_W-1:0]  off_next,
   output logic [SIZE_W-1:0] left_next,
   output logic [FILL_W-1:0] fill_sum,
   output logic              full
);

   localparam int PO_W = (PG_W < OFF_W) ? PG_W : OFF_W;
   localparam int ROOM_W = PG_W + 1;
   localparam int CMP_W = (ROOM_W > SIZE_W) ? ROOM_W : SIZE_W;
   localparam int SUM_W = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 1;
   localparam logic [FILL_W-1:0] FULL_VALUE = FILL_W'(PAGE_BYTES);
   localparam logic CAN_FILL = (PAGE_BYTES < (2 ** FILL_W));

   logic [ROOM_W-1:0] room;
   logic [CMP_W-1:0]  room_cmp;
   logic [CMP_W-1:0]  left_cmp;
   logic [SUM_W-1:0]  off_sum;

   always_comb begin
      room = ROOM_W'(PAGE_BYTES) - ROOM_W'(off[PO_W-1:0]);
      room_cmp = CMP_W'(room);
      left_cmp = CMP_W'(left);
      if (left_cmp < room_cmp) begin
         chunk = left;
      end else begin
         chunk = SIZE_W'(room_cmp);
      end
      off_sum = SUM_W'(off) + SUM_W'(chunk);
      off_next = off_sum[OFF_W-1:0];
      left_next = left - chunk;
      fill_sum = fill_rd + chunk[FILL_W-1:0];
      full = CAN_FILL && (fill_rd == FULL_VALUE);
   end

endmodule

// ----- src/lpft_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the log page fill tracker: clearing pass, read and update steps, response.
// Depends on lpft_pkg.
module lpft_ctrl
   import lpft_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (stat.start) begin
               if (stat.req_probe || !stat.req_size_zero) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stat.item_probe || stat.last_chunk) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.busy = 1'b1;
            ctrl.clear_we = !stat.clear_done;
         end
         ST_IDLE: begin
            ctrl.load = stat.start;
         end
         ST_READ: begin
            ctrl.busy = 1'b1;
            ctrl.rd_en = 1'b1;
         end
         ST_UPDATE: begin
            ctrl.busy = 1'b1;
            ctrl.update = 1'b1;
         end
         ST_RESP: begin
            ctrl.busy = 1'b1;
            ctrl.resp = 1'b1;
         end
         default: begin
            ctrl.busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- src/log_page_fill_tracker_core.sv -----
`timescale 1ns / 1ps
// Record item: accept, then a read and an update step for each page touched, then the response.
// Probe item: accept, one read and one update step, then the response; a zero-size record skips
// the steps. The result strobe comes in the response step; the page counter RAM port sets the pace.
// After reset the block is busy while it clears all BUFFER_BYTES / PAGE_BYTES page counters.
// Reset is synchronous; the receiver cannot stall, so each result is shown for one cycle only.
`include "log_page_fill_tracker_core_assert.svh"
module log_page_fill_tracker_core
   import lpft_pkg::*;
#(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_op,
   input  logic [POS_W-1:0]  req_start_position,
   input  logic [SIZE_W-1:0] req_record_size,
   output logic              rsp_valid,
   output logic              rsp_page_retired,
   output logic [POS_W-1:0]  rsp_frontier
);

   localparam int OFF_W = $clog2(BUFFER_BYTES);
   localparam int PG_W = $clog2(PAGE_BYTES);
   localparam int IDX_W = (OFF_W > PG_W) ? (OFF_W - PG_W) : 1;
   localparam int PAGE_COUNT = (OFF_W > PG_W) ? (2 ** (OFF_W - PG_W)) : 1;

   ctrl_type ctrl;
   stat_type stat;

   logic              op_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [SIZE_W-1:0] left_ff;
   logic [POS_W-1:0]  frontier_ff;
   logic              retired_ff;
   logic [IDX_W:0]    clr_ff;

   logic [IDX_W-1:0]  off_idx;
   logic [IDX_W-1:0]  frontier_idx;
   logic [IDX_W-1:0]  page_addr;
   logic [IDX_W-1:0]  ram_waddr;
   logic [FILL_W-1:0] ram_wdata;
   logic              ram_we;
   logic [FILL_W-1:0] fill_rd;

   logic [SIZE_W-1:0] chunk;
   logic [OFF_W-1:0]  off_next;
   logic [SIZE_W-1:0] left_next;
   logic [FILL_W-1:0] fill_sum;
   logic              full;

   lpft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   lpft_step #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_step (
      .off       (off_ff),
      .left      (left_ff),
      .fill_rd   (fill_rd),
      .chunk     (chunk),
      .off_next  (off_next),
      .left_next (left_next),
      .fill_sum  (fill_sum),
      .full      (full)
   );

   lpft_ram #(
      .WIDTH (FILL_W),
      .DEPTH (PAGE_COUNT)
   ) u_fill_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctrl.rd_en),
      .raddr (page_addr),
      .rdata (fill_rd)
   );

   always_comb begin
      off_idx = IDX_W'(off_ff >> PG_W);
      frontier_idx = IDX_W'(frontier_ff[OFF_W-1:0] >> PG_W);
      page_addr = (op_ff == OP_PROBE) ? frontier_idx : off_idx;
      if (ctrl.clear_we) begin
         ram_we = 1'b1;
         ram_waddr = clr_ff[IDX_W-1:0];
         ram_wdata = '0;
      end else if (op_ff == OP_PROBE) begin
         ram_we = ctrl.update && full;
         ram_waddr = page_addr;
         ram_wdata = '0;
      end else begin
         ram_we = ctrl.update;
         ram_waddr = page_addr;
         ram_wdata = fill_sum;
      end
   end

   always_comb begin
      stat.start = start;
      stat.clear_done = (clr_ff == (IDX_W + 1)'(PAGE_COUNT));
      stat.item_probe = (op_ff == OP_PROBE);
      stat.req_probe = (req_op == OP_PROBE);
      stat.req_size_zero = (req_record_size == '0);
      stat.last_chunk = (left_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.clear_we) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frontier_ff <= '0;
      end else if (ctrl.update && (op_ff == OP_PROBE) && full) begin
         frontier_ff <= frontier_ff + POS_W'(PAGE_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff <= req_op;
         off_ff <= req_start_position[OFF_W-1:0];
         left_ff <= req_record_size;
         retired_ff <= 1'b0;
      end else if (ctrl.update) begin
         if (op_ff == OP_PROBE) begin
            retired_ff <= full;
         end else begin
            off_ff <= off_next;
            left_ff <= left_next;
         end
      end
   end

   assign busy = ctrl.busy;
   assign rsp_valid = ctrl.resp;
   assign rsp_page_retired = ctrl.resp && retired_ff;
   assign rsp_frontier = frontier_ff;

   `LPFT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `LPFT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `LPFT_ASSERT_IMPLIES(a_resp_busy, clock, reset, rsp_valid, busy)

endmodule
